// ===== design/bsws_pkg.sv =====
// shared types and constants of the block sliding window sum
`default_nettype none
package bsws_pkg;

  // fixed field widths
  localparam int SIZE_W  = 16;
  localparam int PART_W  = 28;
  localparam int SUM_W   = 34;
  localparam int SLACK_W = 12;
  localparam int BS_W    = 13;
  localparam int BU_W    = 7;

  // beat widths, padded to whole bytes
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_BLOCK_SIZE    = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_idx_t;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST    = 13'd16;
  localparam logic [BU_W-1:0] BLOCKS_IN_USE_RST = 7'd8;

  // control broadcast to every cell of the block ring
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/bsws_cell.sv =====
// one cell of the block ring: holds one closed block total
`default_nettype none
module bsws_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  bsws_pkg::cell_ctrl_t         ctrl,
  input  wire                          is_tail,
  input  wire [bsws_pkg::PART_W-1:0]   new_total,
  input  wire [bsws_pkg::PART_W-1:0]   neighbor_total,
  output logic [bsws_pkg::PART_W-1:0]  held_total
);

  logic [bsws_pkg::PART_W-1:0] held_r;
  logic [bsws_pkg::PART_W-1:0] held_nxt;

  // tail cell takes the freshly closed block, others take their neighbor
  always_comb begin
    held_nxt = held_r;
    if (ctrl.clear) begin
      held_nxt = '0;
    end else if (ctrl.shift) begin
      held_nxt = is_tail ? new_total : neighbor_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign held_total = held_r;

endmodule
`default_nettype wire

// ===== design/bsws_out.sv =====
// output stage: saturating window sum and the result register
`default_nettype none
module bsws_out (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                up_valid,
  output logic                               up_ready,
  input  wire [bsws_pkg::SUM_W-1:0]          up_running,
  input  wire [bsws_pkg::PART_W-1:0]         up_partial,
  input  wire [bsws_pkg::SLACK_W-1:0]        up_slack,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // fields from bit 0: window_sum (34), slack (12), zero pad (2)
  output logic [bsws_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int SUM_W   = bsws_pkg::SUM_W;
  localparam int SLACK_W = bsws_pkg::SLACK_W;
  localparam int PAD_W   = bsws_pkg::OUT_DATA_W - SUM_W - SLACK_W;

  logic               valid_r;
  logic               valid_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SLACK_W-1:0] slack_r;
  logic [SUM_W:0]     wide_sum;

  // register is free or being emptied this cycle
  assign up_ready = !valid_r || out_tready;

  // saturate at all ones
  always_comb begin
    wide_sum = {1'b0, up_running} + (SUM_W + 1)'(up_partial);
    sum_nxt  = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sum_r   <= sum_nxt;
      slack_r <= up_slack;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, slack_r, sum_r};

endmodule
`default_nettype wire

// ===== design/block_sliding_window_sum.sv =====
// A result is registered in the snapshot stage, then in the result register.
// Throughput: one beat per cycle while the result stream does not stall; the
//   partial-block add, the running-sum update and the ring shift all complete
//   in the accept cycle. Reset (rst_n, synchronous): ring cells, partial and
//   running sums, count and valids clear; block_size returns to 16, blocks_in_use
//   to 8. A register write also clears ring, sums and count in the same cycle.
`default_nettype none
module block_sliding_window_sum #(
  parameter int MAX_BLOCKS     = 64,
  parameter int MAX_BLOCK_SIZE = 4096
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration port
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire [bsws_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire [bsws_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [bsws_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready,
  // input stream
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // fields from bit 0: packet_size (16)
  input  wire [bsws_pkg::IN_DATA_W-1:0]        in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // fields from bit 0: window_sum (34), slack (12), zero pad (2)
  output logic [bsws_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int SIZE_W  = bsws_pkg::SIZE_W;
  localparam int PART_W  = bsws_pkg::PART_W;
  localparam int SUM_W   = bsws_pkg::SUM_W;
  localparam int SLACK_W = bsws_pkg::SLACK_W;
  localparam int BS_W    = bsws_pkg::BS_W;
  localparam int BU_W    = bsws_pkg::BU_W;
  localparam int DATA_W  = bsws_pkg::CFG_DATA_W;
  localparam int ADDR_W  = bsws_pkg::CFG_ADDR_W;

  // item counter holds up to the clamped block size
  localparam int CNT_W   = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int EBS_W   = (CNT_W > BS_W) ? CNT_W : BS_W;
  // ring length compare width
  localparam int NBC_W   = $clog2(MAX_BLOCKS + 1);
  localparam int NB_W    = (NBC_W > BU_W) ? NBC_W : BU_W;

  // configuration registers
  logic [BS_W-1:0]  block_size_r;
  logic [BS_W-1:0]  block_size_nxt;
  logic [BU_W-1:0]  blocks_in_use_r;
  logic [BU_W-1:0]  blocks_in_use_nxt;
  logic             cfg_wr;
  bsws_pkg::reg_idx_t cfg_idx;

  // window state
  logic [PART_W-1:0] partial_r;
  logic [PART_W-1:0] partial_nxt;
  logic [CNT_W-1:0]  items_r;
  logic [CNT_W-1:0]  items_nxt;
  logic [SUM_W-1:0]  running_r;
  logic [SUM_W-1:0]  running_nxt;

  // result snapshot stage
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [SUM_W-1:0]   s1_run_r;
  logic [PART_W-1:0]  s1_part_r;
  logic [SLACK_W-1:0] s1_slack_r;
  logic               s2_ready;

  // per-item datapath
  logic              accept;
  logic [SIZE_W-1:0] packet_size;
  logic [PART_W-1:0] part_add;
  logic [CNT_W-1:0]  items_inc;
  logic [EBS_W-1:0]  eff_bs;
  logic [EBS_W-1:0]  bs_ext;
  logic              close;
  logic [SUM_W-1:0]  run_close;
  logic [NB_W-1:0]   bu_ext;
  logic [NB_W-1:0]   nblk;
  logic [NB_W-1:0]   tail;

  // ring wiring: index MAX_BLOCKS is the zero fed into the last cell
  logic [PART_W-1:0]    cell_total [MAX_BLOCKS+1];
  bsws_pkg::cell_ctrl_t ring_ctrl;

  // register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = bsws_pkg::reg_idx_t'(cfg_paddr[ADDR_W-1]);

  always_comb begin
    block_size_nxt    = block_size_r;
    blocks_in_use_nxt = blocks_in_use_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        bsws_pkg::REG_BLOCK_SIZE:    block_size_nxt    = cfg_pwdata[BS_W-1:0];
        bsws_pkg::REG_BLOCKS_IN_USE: blocks_in_use_nxt = cfg_pwdata[BU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r    <= bsws_pkg::BLOCK_SIZE_RST;
      blocks_in_use_r <= bsws_pkg::BLOCKS_IN_USE_RST;
    end else begin
      block_size_r    <= block_size_nxt;
      blocks_in_use_r <= blocks_in_use_nxt;
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      bsws_pkg::REG_BLOCK_SIZE:    cfg_prdata = DATA_W'(block_size_r);
      bsws_pkg::REG_BLOCKS_IN_USE: cfg_prdata = DATA_W'(blocks_in_use_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // clamp block size into 1..MAX_BLOCK_SIZE
  always_comb begin
    bs_ext = EBS_W'(block_size_r);
    if (block_size_r == '0) begin
      eff_bs = EBS_W'(1);
    end else if (bs_ext > EBS_W'(MAX_BLOCK_SIZE)) begin
      eff_bs = EBS_W'(MAX_BLOCK_SIZE);
    end else begin
      eff_bs = bs_ext;
    end
  end

  // clamp ring length into 1..MAX_BLOCKS, tail cell takes new blocks
  always_comb begin
    bu_ext = NB_W'(blocks_in_use_r);
    if (blocks_in_use_r == '0) begin
      nblk = NB_W'(1);
    end else if (bu_ext > NB_W'(MAX_BLOCKS)) begin
      nblk = NB_W'(MAX_BLOCKS);
    end else begin
      nblk = bu_ext;
    end
    tail = nblk - NB_W'(1);
  end

  // item accumulation and block close
  assign accept      = in_tvalid && in_tready;
  assign packet_size = in_tdata[SIZE_W-1:0];
  assign part_add    = partial_r + PART_W'(packet_size);
  assign items_inc   = items_r + CNT_W'(1);
  assign close       = EBS_W'(items_inc) >= eff_bs;
  assign run_close   = running_r + SUM_W'(part_add) - SUM_W'(cell_total[0]);

  always_comb begin
    partial_nxt = partial_r;
    items_nxt   = items_r;
    running_nxt = running_r;
    if (cfg_wr) begin
      partial_nxt = '0;
      items_nxt   = '0;
      running_nxt = '0;
    end else if (accept) begin
      if (close) begin
        partial_nxt = '0;
        items_nxt   = '0;
        running_nxt = run_close;
      end else begin
        partial_nxt = part_add;
        items_nxt   = items_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      items_r   <= '0;
      running_r <= '0;
    end else begin
      partial_r <= partial_nxt;
      items_r   <= items_nxt;
      running_r <= running_nxt;
    end
  end

  // block ring as a row of cells, oldest block in cell 0
  assign ring_ctrl.clear         = cfg_wr;
  assign ring_ctrl.shift         = accept && close;
  assign cell_total[MAX_BLOCKS]  = '0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_ring
    bsws_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ring_ctrl),
      .is_tail        (tail == NB_W'(i)),
      .new_total      (part_add),
      .neighbor_total (cell_total[i+1]),
      .held_total     (cell_total[i])
    );
  end

  // snapshot of the state after this beat
  assign in_tready = !s1_valid_r || s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_run_r   <= close ? run_close : running_r;
      s1_part_r  <= close ? '0 : part_add;
      s1_slack_r <= close ? '0 : SLACK_W'(items_inc);
    end
  end

  // saturating sum and result register
  bsws_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s1_valid_r),
    .up_ready   (s2_ready),
    .up_running (s1_run_r),
    .up_partial (s1_part_r),
    .up_slack   (s1_slack_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/sv/block_sliding_window_sum_tb.sv =====
// testbench for the block sliding window sum: directed table and random phases
`timescale 1ns / 1ps
`default_nettype none
module block_sliding_window_sum_tb;

  localparam int SIZE_W     = bsws_pkg::SIZE_W;
  localparam int PART_W     = bsws_pkg::PART_W;
  localparam int SUM_W      = bsws_pkg::SUM_W;
  localparam int SLACK_W    = bsws_pkg::SLACK_W;
  localparam int BS_W       = bsws_pkg::BS_W;
  localparam int BU_W       = bsws_pkg::BU_W;
  localparam int IN_DATA_W  = bsws_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = bsws_pkg::OUT_DATA_W;
  localparam int CFG_ADDR_W = bsws_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = bsws_pkg::CFG_DATA_W;

  localparam int LONG_STALL     = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RING_MAX       = 64;
  localparam int BLOCK_MAX      = 4096;

  typedef struct packed {
    logic [SLACK_W-1:0] slack;
    logic [SUM_W-1:0]   window_sum;
  } window_result_t;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bsws_pkg::reg_idx_t idx;
    logic [31:0]        value;
    bit                 typed;
    logic [SUM_W-1:0]   sum;
    logic [SLACK_W-1:0] slack;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // fields from bit 0: packet_size (16)
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // fields from bit 0: window_sum (34), slack (12), zero pad (2)
  logic [OUT_DATA_W-1:0] out_tdata;

  block_sliding_window_sum dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // window state mirrored by the predictor
  logic [PART_W-1:0]  win_ring [RING_MAX];
  logic [5:0]         win_head;
  logic [PART_W-1:0]  win_partial;
  logic [SLACK_W-1:0] win_count;
  logic [SUM_W-1:0]   win_running;
  logic [BS_W-1:0]    win_block_size;
  logic [BU_W-1:0]    win_ring_len;

  window_result_t expected_sums [$];
  stim_row_t      dir_rows [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_trigger  = 0;
  int stall_seen     = 0;
  int stall_left     = 0;
  int err_count      = 0;
  int sizes_sent     = 0;
  int sums_checked   = 0;
  int reg_writes     = 0;
  int quiet_cycles   = 0;

  function automatic void clear_window();
    foreach (win_ring[i]) win_ring[i] = '0;
    win_head    = '0;
    win_partial = '0;
    win_count   = '0;
    win_running = '0;
  endfunction

  // one packet size through the window, returns the sum and slack after it
  function automatic window_result_t window_step(logic [SIZE_W-1:0] size);
    int blk_items;
    int ring_len;
    int slot;
    int count_next;
    logic [SUM_W:0] total;
    window_result_t res;
    blk_items = (win_block_size == 0) ? 1 :
                (win_block_size > BLOCK_MAX) ? BLOCK_MAX : int'(win_block_size);
    ring_len  = (win_ring_len == 0) ? 1 :
                (win_ring_len > RING_MAX) ? RING_MAX : int'(win_ring_len);
    win_partial = win_partial + PART_W'(size);
    count_next  = int'(win_count) + 1;
    if (count_next >= blk_items) begin
      slot = int'(win_head);
      if (slot >= ring_len) slot = 0;
      win_running   = win_running + SUM_W'(win_partial) - SUM_W'(win_ring[slot]);
      win_ring[slot] = win_partial;
      slot++;
      win_head    = (slot >= ring_len) ? 6'd0 : 6'(slot);
      win_partial = '0;
      win_count   = '0;
    end else begin
      win_count = SLACK_W'(count_next);
    end
    total = {1'b0, win_running} + (SUM_W+1)'(win_partial);
    if (total[SUM_W]) begin
      res.window_sum = '1;
    end else begin
      res.window_sum = total[SUM_W-1:0];
    end
    res.slack = win_count;
    return res;
  endfunction

  function automatic void add_row(row_kind_t kind, bsws_pkg::reg_idx_t idx,
                                  logic [31:0] value,
                                  bit typed, logic [SUM_W-1:0] sum,
                                  logic [SLACK_W-1:0] slack);
    stim_row_t row;
    row.kind  = kind;
    row.idx   = idx;
    row.value = value;
    row.typed = typed;
    row.sum   = sum;
    row.slack = slack;
    dir_rows.push_back(row);
  endfunction

  // offer one packet size, push its expected sum once accepted
  task automatic send_size(input logic [SIZE_W-1:0] size, input bit typed = 0,
                           input window_result_t typed_res = '0);
    window_result_t res;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= size;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = window_step(size);
    expected_sums.push_back(typed ? typed_res : res);
    sizes_sent++;
  endtask

  // drop valid and let every outstanding sum come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup and access cycles, mirror the write in the predictor
  task automatic write_reg(input bsws_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == bsws_pkg::REG_BLOCK_SIZE) win_block_size = value[BS_W-1:0];
    else win_ring_len = value[BU_W-1:0];
    clear_window();
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return SIZE_W'(1) << $urandom_range(SIZE_W-1);
    return SIZE_W'($urandom);
  endfunction

  // register word with random junk above the field half of the time
  function automatic logic [31:0] reg_word(int field_w, int value);
    logic [31:0] word;
    word = $urandom;
    if ($urandom_range(1)) word = '0;
    word = (word >> field_w) << field_w;
    return word | 32'(value);
  endfunction

  function automatic logic [31:0] pick_block_size();
    int r;
    int v;
    r = $urandom_range(19);
    if (r == 0) v = 0;
    else if (r == 1) v = BLOCK_MAX;
    else if (r == 2) v = $urandom_range(8191, BLOCK_MAX + 1);
    else if (r == 3) v = $urandom_range(40, 7);
    else v = $urandom_range(6, 1);
    return reg_word(BS_W, v);
  endfunction

  function automatic logic [31:0] pick_ring_len();
    int r;
    int v;
    r = $urandom_range(9);
    if (r == 0) v = 0;
    else if (r == 1) v = $urandom_range(127, RING_MAX + 1);
    else if (r == 2) v = RING_MAX;
    else if (r == 3) v = $urandom_range(63, 5);
    else v = $urandom_range(4, 1);
    return reg_word(BU_W, v);
  endfunction

  // compare a result beat with the oldest expected sum
  task automatic check_sum(input logic [OUT_DATA_W-1:0] beat);
    window_result_t want;
    if (expected_sums.size() == 0) begin
      $display("%0t: result beat with nothing expected, got %h", $time, beat);
      err_count++;
    end else begin
      want = expected_sums.pop_front();
      if (beat[SUM_W-1:0] !== want.window_sum) begin
        $display("%0t: window_sum mismatch, expected %0d, got %0d",
                 $time, want.window_sum, beat[SUM_W-1:0]);
        err_count++;
      end
      if (beat[SUM_W +: SLACK_W] !== want.slack) begin
        $display("%0t: slack mismatch, expected %0d, got %0d",
                 $time, want.slack, beat[SUM_W +: SLACK_W]);
        err_count++;
      end
      sums_checked++;
    end
  endtask

  // result side: check beats, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) check_sum(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_trigger != stall_seen) begin
      stall_seen = stall_trigger;
      stall_left = LONG_STALL;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d sums outstanding",
               $time, WATCHDOG_LIMIT, expected_sums.size());
      $display("[block_sliding_window_sum] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    window_result_t typed_res;
    int ph;
    int seg;
    int k;
    // directed rows, reset values 16 items per block and 8 blocks
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd0, 1, 34'd0, 12'd1);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd65535, 1, 34'd65535, 12'd2);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd1, 0, '0, '0);
    // zero block size closes a block on every item
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCK_SIZE, 32'd0, 0, '0, '0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd65535, 1, 34'd65535, 12'd0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd5, 1, 34'd65540, 12'd0);
    // zero ring length keeps a single block
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCKS_IN_USE, 32'hABCD_EF80, 0, '0, '0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd7, 1, 34'd7, 12'd0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd3, 1, 34'd3, 12'd0);
    // oversized ring length and block size clamp to the maximum
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCKS_IN_USE, 32'hFFFF_FF7F, 0, '0, '0);
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCK_SIZE, 32'hFFFF_FFFF, 0, '0, '0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd65535, 1, 34'd65535, 12'd1);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd65535, 1, 34'd131070, 12'd2);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'd32768, 0, '0, '0);
    // two blocks of two items, the ring wraps and evicts
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCK_SIZE, 32'd2, 0, '0, '0);
    add_row(ROW_WRITE, bsws_pkg::REG_BLOCKS_IN_USE, 32'd2, 0, '0, '0);
    for (k = 1; k <= 6; k++) begin
      add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'(10 * k), 0, '0, '0);
    end
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'h5555, 0, '0, '0);
    add_row(ROW_ITEM, bsws_pkg::REG_BLOCK_SIZE, 32'hAAAA, 0, '0, '0);

    win_block_size = bsws_pkg::BLOCK_SIZE_RST;
    win_ring_len   = bsws_pkg::BLOCKS_IN_USE_RST;
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        typed_res.window_sum = dir_rows[i].sum;
        typed_res.slack      = dir_rows[i].slack;
        send_size(dir_rows[i].value[SIZE_W-1:0], dir_rows[i].typed, typed_res);
      end
    end

    // random phases: free running, sender idle, receiver stalling, both
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 35 : 0;
      recv_stall_pct = (ph == 2) ? 79 : (ph == 3) ? 35 : 0;
      for (seg = 0; seg < 4; seg++) begin
        wait_idle();
        write_reg(bsws_pkg::REG_BLOCK_SIZE, pick_block_size());
        write_reg(bsws_pkg::REG_BLOCKS_IN_USE, pick_ring_len());
        // long receiver hold-off while sizes keep coming
        if (ph == 0 && seg == 1) stall_trigger++;
        for (k = 0; k < 28; k++) send_size(pick_size());
      end
    end

    wait_idle();

    $display("sent %0d packet sizes and checked %0d sums over %0d register writes",
             sizes_sent, sums_checked, reg_writes);
    $display("zero, clamped and random settings, ring wrap and a long receiver stall covered");
    if (err_count == 0) begin
      $display("[block_sliding_window_sum] OK");
    end else begin
      $display("[block_sliding_window_sum] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/bsws_pkg.sv
design/bsws_cell.sv
design/bsws_out.sv
design/block_sliding_window_sum.sv
tb/sv/block_sliding_window_sum_tb.sv
